// File: rtl/core/fbld_pkg.sv
`default_nettype none

package fbld_pkg;

  // Frame store geometry: one byte holds eight rows of one column
  localparam int unsigned STORE_DEPTH = 864;
  localparam int unsigned ADDR_W      = 10;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COORD_W     = 8;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned ERR_W       = 10;
  localparam int unsigned IDX_W       = 13;

  // Panel defaults
  localparam int unsigned PANEL_WIDTH_DEF  = 96;
  localparam int unsigned PANEL_HEIGHT_DEF = 68;
  localparam int unsigned PAGE_COUNT_DEF   = 9;

  // Command codes carried on tuser
  typedef enum logic [1:0] {
    FUNC_DRAW  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  // Line walker phases
  typedef enum logic [1:0] {
    WALK_IDLE  = 2'd0,
    WALK_SETUP = 2'd1,
    WALK_STEP  = 2'd2
  } walk_phase_e;

  // Top-level sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_CLEAR = 3'd1,
    ST_DRAW  = 3'd2,
    ST_DRAIN = 3'd3,
    ST_READ  = 3'd4,
    ST_OUT   = 3'd5
  } top_state_e;

  // One pixel produced by the walker
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pixel_t;

endpackage

`default_nettype wire

// File: rtl/core/fbld_ram.sv
`default_nettype none

module fbld_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 864,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one word, read one word; a read of the address being written returns old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/fbld_walker.sv
`default_nettype none

module fbld_walker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [fbld_pkg::COORD_W-1:0]  start_x_i,
  input  wire logic [fbld_pkg::COORD_W-1:0]  start_y_i,
  input  wire logic [fbld_pkg::COORD_W-1:0]  end_x_i,
  input  wire logic [fbld_pkg::COORD_W-1:0]  end_y_i,
  output fbld_pkg::pixel_t                   pixel_o
);

  localparam int unsigned CW = fbld_pkg::COORD_W;
  localparam int unsigned EW = fbld_pkg::ERR_W;

  fbld_pkg::walk_phase_e phase_q, phase_d;

  logic          steep_q, up_q;
  logic [CW-1:0] ax_q, ay_q, bx_q, by_q;
  logic [CW-1:0] major_q, minor_q, end_q, dx_q, dy_q;
  logic [EW-1:0] err_q;

  logic [CW-1:0] adx, ady;
  logic          steep, swap, last;
  logic [CW-1:0] lo_major, lo_minor, hi_major, hi_minor;
  logic [EW-1:0] err_sub;

  // Axis lengths of the incoming command
  assign adx   = (start_x_i > end_x_i) ? start_x_i - end_x_i : end_x_i - start_x_i;
  assign ady   = (start_y_i > end_y_i) ? start_y_i - end_y_i : end_y_i - start_y_i;
  assign steep = ady > adx;

  // Order endpoints along the major axis
  assign swap     = ax_q > bx_q;
  assign lo_major = swap ? bx_q : ax_q;
  assign lo_minor = swap ? by_q : ay_q;
  assign hi_major = swap ? ax_q : bx_q;
  assign hi_minor = swap ? ay_q : by_q;

  // Shared error update: subtract dy, the sign bit says when to move the minor axis
  assign err_sub = err_q - {{(EW-CW){1'b0}}, dy_q};
  assign last    = major_q == end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fbld_pkg::WALK_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    phase_d       = phase_q;
    pixel_o.valid = 1'b0;
    pixel_o.last  = last;
    pixel_o.x     = steep_q ? minor_q : major_q;
    pixel_o.y     = steep_q ? major_q : minor_q;
    unique case (phase_q)
      fbld_pkg::WALK_IDLE: begin
        if (start_i) begin
          phase_d = fbld_pkg::WALK_SETUP;
        end
      end
      fbld_pkg::WALK_SETUP: begin
        phase_d = fbld_pkg::WALK_STEP;
      end
      fbld_pkg::WALK_STEP: begin
        pixel_o.valid = 1'b1;
        if (last) begin
          phase_d = fbld_pkg::WALK_IDLE;
        end
      end
      default: begin
        phase_d = fbld_pkg::WALK_IDLE;
      end
    endcase
  end

  // Walker datapath
  always_ff @(posedge clk_i) begin
    if (phase_q == fbld_pkg::WALK_IDLE && start_i) begin
      steep_q <= steep;
      ax_q    <= steep ? start_y_i : start_x_i;
      ay_q    <= steep ? start_x_i : start_y_i;
      bx_q    <= steep ? end_y_i : end_x_i;
      by_q    <= steep ? end_x_i : end_y_i;
    end
    if (phase_q == fbld_pkg::WALK_SETUP) begin
      major_q <= lo_major;
      minor_q <= lo_minor;
      end_q   <= hi_major;
      dx_q    <= hi_major - lo_major;
      dy_q    <= (lo_minor > hi_minor) ? lo_minor - hi_minor : hi_minor - lo_minor;
      up_q    <= lo_minor < hi_minor;
      err_q   <= {{(EW-CW+1){1'b0}}, hi_major[CW-1:1] - lo_major[CW-1:1]
                  - {{(CW-2){1'b0}}, (lo_major[0] & ~hi_major[0])}};
    end
    if (phase_q == fbld_pkg::WALK_STEP) begin
      major_q <= major_q + 1'b1;
      if (err_sub[EW-1]) begin
        err_q   <= err_sub + {{(EW-CW){1'b0}}, dx_q};
        minor_q <= up_q ? minor_q + 1'b1 : minor_q - 1'b1;
      end else begin
        err_q   <= err_sub;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/framebuffer_line_draw.sv
// One-bit-per-pixel page-organized framebuffer with a line engine.
// Commands enter on the s_axis channel; func travels on tuser (draw line,
// clear store, read byte). Each command returns exactly one transaction on
// m_axis with the byte read (read only) and the count of pixels written
// (draw only); other fields return zero.
// Sequence from acceptance to m_axis_tvalid:
//   draw:  walker setup, then one pixel read-modify-write per cycle
//          through the frame RAM, then a pipeline drain state
//   clear: one RAM word zeroed per cycle across the whole store
//   read:  registered RAM read; unused func: straight to the result
// One command is in flight at a time; s_axis_tready is high only while idle.
// After reset the block sweeps all 864 RAM words to zero with s_axis_tready
// low, and emits no transaction for it.
// A stalled m_axis_tready holds the result and keeps s_axis_tready low.
`default_nettype none

module framebuffer_line_draw #(
  parameter int unsigned PANEL_WIDTH  = fbld_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT = fbld_pkg::PANEL_HEIGHT_DEF,
  parameter int unsigned PAGE_COUNT   = fbld_pkg::PAGE_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // start_x[7:0], start_y[15:8], end_x[23:16], end_y[31:24], ink[32],
  // read_address[42:33], zero[47:43]
  input  wire logic [47:0] s_axis_tdata,
  // func[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_data[7:0], pixels_plotted[16:8], zero[23:17]
  output logic [23:0]      m_axis_tdata
);

  localparam int unsigned AW = fbld_pkg::ADDR_W;
  localparam int unsigned BW = fbld_pkg::BYTE_W;
  localparam int unsigned CW = fbld_pkg::COORD_W;
  localparam int unsigned NW = fbld_pkg::COUNT_W;
  localparam int unsigned IW = fbld_pkg::IDX_W;
  localparam int unsigned PW = CW - 3;

  // Unpack command
  logic [1:0]    func;
  logic [CW-1:0] start_x, start_y, end_x, end_y;
  logic          ink;
  logic [AW-1:0] read_address;

  assign func         = s_axis_tuser;
  assign start_x      = s_axis_tdata[7:0];
  assign start_y      = s_axis_tdata[15:8];
  assign end_x        = s_axis_tdata[23:16];
  assign end_y        = s_axis_tdata[31:24];
  assign ink          = s_axis_tdata[32];
  assign read_address = s_axis_tdata[42:33];

  fbld_pkg::top_state_e state_q, state_d;

  logic          accept, draw_start;
  logic [NW-1:0] count_q;
  logic [AW-1:0] clr_cnt_q;
  logic          clr_cmd_q, p1_valid_q, last_valid_q;
  logic [BW-1:0] rdata_q, p1_mask_q, last_data_q;
  logic [AW-1:0] p1_addr_q, last_addr_q;
  logic          ink_q, rd_ok_q;

  fbld_pkg::pixel_t pixel;
  logic [PW-1:0]    page;
  logic [IW-1:0]    idx;
  logic             hit;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [BW-1:0] ram_wdata, ram_rdata;
  logic [BW-1:0] old_byte, new_byte;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign draw_start = accept && (func == fbld_pkg::FUNC_DRAW);

  fbld_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (draw_start),
    .start_x_i (start_x),
    .start_y_i (start_y),
    .end_x_i   (end_x),
    .end_y_i   (end_y),
    .pixel_o   (pixel)
  );

  // Map pixel to store byte and drop pixels off the panel or beyond the store
  assign page = pixel.y[CW-1:3];
  assign idx  = IW'(pixel.x) + IW'(page) * IW'(PANEL_WIDTH);
  assign hit  = pixel.valid && (state_q == fbld_pkg::ST_DRAW)
             && ({1'b0, pixel.x} < (CW+1)'(PANEL_WIDTH))
             && ({1'b0, pixel.y} < (CW+1)'(PANEL_HEIGHT))
             && ({1'b0, page} < (PW+1)'(PAGE_COUNT))
             && (idx < IW'(fbld_pkg::STORE_DEPTH));

  // Modify stage: forward the previous write when it hit the same byte
  assign old_byte = (last_valid_q && last_addr_q == p1_addr_q) ? last_data_q : ram_rdata;
  assign new_byte = ink_q ? (old_byte | p1_mask_q) : (old_byte & ~p1_mask_q);

  // RAM port selection
  always_comb begin
    ram_raddr = (state_q == fbld_pkg::ST_DRAW) ? idx[AW-1:0] : read_address;
    if (state_q == fbld_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = p1_valid_q;
      ram_waddr = p1_addr_q;
      ram_wdata = new_byte;
    end
  end

  fbld_ram #(
    .WIDTH  (BW),
    .DEPTH  (fbld_pkg::STORE_DEPTH),
    .ADDR_W (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbld_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      fbld_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          case (func)
            fbld_pkg::FUNC_DRAW:  state_d = fbld_pkg::ST_DRAW;
            fbld_pkg::FUNC_CLEAR: state_d = fbld_pkg::ST_CLEAR;
            fbld_pkg::FUNC_READ:  state_d = fbld_pkg::ST_READ;
            default:              state_d = fbld_pkg::ST_OUT;
          endcase
        end
      end
      fbld_pkg::ST_CLEAR: begin
        if (clr_cnt_q == AW'(fbld_pkg::STORE_DEPTH - 1)) begin
          state_d = clr_cmd_q ? fbld_pkg::ST_OUT : fbld_pkg::ST_IDLE;
        end
      end
      fbld_pkg::ST_DRAW: begin
        if (pixel.valid && pixel.last) begin
          state_d = fbld_pkg::ST_DRAIN;
        end
      end
      fbld_pkg::ST_DRAIN: begin
        state_d = fbld_pkg::ST_OUT;
      end
      fbld_pkg::ST_READ: begin
        state_d = fbld_pkg::ST_OUT;
      end
      fbld_pkg::ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          state_d = fbld_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fbld_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers: clear sweep, pixel count, pipeline valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q    <= '0;
      clr_cmd_q    <= 1'b0;
      count_q      <= '0;
      p1_valid_q   <= 1'b0;
      last_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= hit;
      if (ram_we) begin
        last_valid_q <= 1'b1;
      end
      if (state_q == fbld_pkg::ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (accept) begin
        clr_cnt_q <= '0;
        clr_cmd_q <= 1'b1;
        count_q   <= '0;
      end else if (hit) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (hit) begin
      p1_addr_q <= idx[AW-1:0];
      p1_mask_q <= BW'(1) << pixel.y[2:0];
    end
    if (ram_we) begin
      last_addr_q <= ram_waddr;
      last_data_q <= ram_wdata;
    end
    if (accept) begin
      ink_q   <= ink;
      rd_ok_q <= read_address < AW'(fbld_pkg::STORE_DEPTH);
      rdata_q <= '0;
    end else if (state_q == fbld_pkg::ST_READ && rd_ok_q) begin
      rdata_q <= ram_rdata;
    end
  end

  assign m_axis_tdata = {{(24 - NW - BW){1'b0}}, count_q, rdata_q};

`ifndef SYNTHESIS
  // The store is never written while a command can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni) ram_we |-> !s_axis_tready)
    else $error("frame RAM written while idle");

  // A draw never reports more pixels than a line can hold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (count_q <= NW'(256)))
    else $error("pixel count overflow");

  // A read result carries no pixel count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fbld_pkg::ST_READ) |=> (m_axis_tvalid && count_q == '0))
    else $error("read result malformed");

  // The modify stage only runs while drawing or draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_valid_q |-> (state_q == fbld_pkg::ST_DRAW || state_q == fbld_pkg::ST_DRAIN))
    else $error("pixel write outside draw");

  // Taking a command closes the input until its result is delivered
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> !s_axis_tready)
    else $error("second command accepted while busy");
`endif

endmodule

`default_nettype wire

// File: tb/sv/framebuffer_line_draw_tb.sv
`timescale 1ns / 1ps

module framebuffer_line_draw_tb;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 50;

  // One command as presented on s_axis
  typedef struct {
    logic [1:0] func;
    logic [7:0] sx;
    logic [7:0] sy;
    logic [7:0] ex;
    logic [7:0] ey;
    logic       ink;
    logic [9:0] addr;
    bit         drain_first;
  } cmd_t;

  // One response as carried on m_axis
  typedef struct {
    logic [7:0] rdata;
    logic [8:0] plotted;
  } result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  cmd_t    cmd_q[$];
  result_t expected_q[$];
  logic [7:0] frame_model [fbld_pkg::STORE_DEPTH];

  bit  cmd_fire = 1'b0;
  int  total_cmds;
  int  accepted_cmds = 0;
  int  results_seen  = 0;
  int  error_count   = 0;
  int  func_count [4] = '{0, 0, 0, 0};
  int  pixels_total  = 0;
  int  nonzero_reads = 0;
  longint cycle_count = 0;
  longint cycle_limit = 64'h7fff_ffff_ffff;

  framebuffer_line_draw DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Free-running clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Set or clear one pixel of the model; report whether it landed in the store
  function automatic bit plot_pixel(int x, int y, bit ink);
    int page;
    int idx;
    if (x >= fbld_pkg::PANEL_WIDTH_DEF || y >= fbld_pkg::PANEL_HEIGHT_DEF) return 1'b0;
    page = y >> 3;
    if (page >= fbld_pkg::PAGE_COUNT_DEF) return 1'b0;
    idx = x + page * fbld_pkg::PANEL_WIDTH_DEF;
    if (idx >= fbld_pkg::STORE_DEPTH) return 1'b0;
    frame_model[idx][y % 8] = ink;
    return 1'b1;
  endfunction

  // Walk a Bresenham line over the model and count the pixels written
  function automatic int trace_line(int ax, int ay, int bx, int by, bit ink);
    int adx;
    int ady;
    int t;
    int dx;
    int dy;
    int err;
    int major;
    int count;
    bit steep;
    bit up;
    logic [7:0] minor;
    adx = (ax > bx) ? ax - bx : bx - ax;
    ady = (ay > by) ? ay - by : by - ay;
    steep = ady > adx;
    if (steep) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
    end
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    dx = bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    err = dx / 2;
    up = ay < by;
    minor = ay[7:0];
    count = 0;
    for (major = ax; major <= bx; major++) begin
      if (steep ? plot_pixel(int'(minor), major, ink) : plot_pixel(major, int'(minor), ink))
        count++;
      err -= dy;
      if (err < 0) begin
        // Minor coordinate wraps within 8 bits
        minor = up ? minor + 8'd1 : minor - 8'd1;
        err += dx;
      end
    end
    return count;
  endfunction

  // Apply one accepted command to the model and return its response
  function automatic result_t predict_result(logic [1:0] func, logic [47:0] data);
    result_t res;
    res.rdata   = '0;
    res.plotted = '0;
    case (func)
      fbld_pkg::FUNC_DRAW: begin
        res.plotted = 9'(trace_line(int'(data[7:0]), int'(data[15:8]), int'(data[23:16]),
                                    int'(data[31:24]), data[32]));
      end
      fbld_pkg::FUNC_CLEAR: begin
        foreach (frame_model[i]) frame_model[i] = '0;
      end
      fbld_pkg::FUNC_READ: begin
        if (int'(data[42:33]) < fbld_pkg::STORE_DEPTH) res.rdata = frame_model[data[42:33]];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_cmd(logic [1:0] func, logic [7:0] sx, logic [7:0] sy,
                                  logic [7:0] ex, logic [7:0] ey, logic ink,
                                  logic [9:0] addr, bit drain_first);
    cmd_t c;
    c.func = func;
    c.sx = sx;
    c.sy = sy;
    c.ex = ex;
    c.ey = ey;
    c.ink = ink;
    c.addr = addr;
    c.drain_first = drain_first;
    cmd_q.push_back(c);
  endfunction

  // Build one random command, weighted toward lines near the panel
  function automatic void add_random_cmd(bit drain_first);
    int pick;
    int shape;
    logic [1:0] func;
    logic [7:0] sx;
    logic [7:0] sy;
    logic [7:0] ex;
    logic [7:0] ey;
    logic       ink;
    logic [9:0] addr;
    pick  = $urandom_range(0, 99);
    shape = $urandom_range(0, 9);
    sx = 8'($urandom());
    sy = 8'($urandom());
    ex = 8'($urandom());
    ey = 8'($urandom());
    ink = ($urandom_range(0, 3) != 0);
    addr = 10'($urandom());
    if (pick < 50) begin
      func = fbld_pkg::FUNC_DRAW;
      if (shape < 4) begin
        // Short segment inside or near the panel
        sx = 8'($urandom_range(0, 110));
        sy = 8'($urandom_range(0, 80));
        ex = sx ^ 8'($urandom_range(0, 15));
        ey = sy ^ 8'($urandom_range(0, 15));
      end else if (shape < 8) begin
        sx = 8'($urandom_range(0, 110));
        sy = 8'($urandom_range(0, 80));
        ex = 8'($urandom_range(0, 110));
        ey = 8'($urandom_range(0, 80));
      end
    end else if (pick < 90) begin
      func = fbld_pkg::FUNC_READ;
      addr = (shape == 0) ? 10'($urandom_range(864, 1023)) : 10'($urandom_range(0, 863));
    end else if (pick < 95) begin
      func = fbld_pkg::FUNC_CLEAR;
    end else begin
      func = FUNC_UNUSED;
    end
    add_cmd(func, sx, sy, ex, ey, ink, addr, drain_first);
  endfunction

  // Report a failure; only the first few are printed
  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Sender: bursts of commands separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk_i) begin : drive_cmds
    cmd_t nxt;
    // Hold the current transaction until it is taken
    if (rst_ni && !(s_axis_tvalid && !cmd_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0 && (!cmd_q[0].drain_first || expected_q.size() == 0))
      begin
        nxt = cmd_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.func;
        s_axis_tdata  <= {5'd0, nxt.addr, nxt.ink, nxt.ey, nxt.ex, nxt.sy, nxt.sx};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: gap_left = 0;
            19:                     gap_left = $urandom_range(200, 400);
            default:                gap_left = $urandom_range(1, 24);
          endcase
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: ready follows a 16-bit pattern reloaded whenever stall_phase wraps to zero
  logic [15:0] stall_pattern = 16'hFFFF;
  int          stall_phase   = 0;

  always @(negedge clk_i) begin : drive_ready
    if (stall_phase == 0) begin
      stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
    end
    m_axis_tready <= stall_pattern[stall_phase % 16];
    stall_phase = (stall_phase + 1) % 64;
  end

  // Score responses, then record newly accepted commands
  always @(posedge clk_i) begin : scoreboard
    result_t want;
    result_t got;
    cmd_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.rdata   = m_axis_tdata[7:0];
        got.plotted = m_axis_tdata[16:8];
        results_seen++;
        if (expected_q.size() == 0) begin
          flag_error($sformatf("unexpected response data=%h plotted=%0d",
                               got.rdata, got.plotted));
        end else begin
          want = expected_q.pop_front();
          if (got.rdata !== want.rdata)
            flag_error($sformatf("response %0d read_data: expected %h, got %h",
                                 results_seen, want.rdata, got.rdata));
          if (got.plotted !== want.plotted)
            flag_error($sformatf("response %0d pixels_plotted: expected %0d, got %0d",
                                 results_seen, want.plotted, got.plotted));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = predict_result(s_axis_tuser, s_axis_tdata);
        expected_q.push_back(want);
        accepted_cmds++;
        func_count[s_axis_tuser]++;
        pixels_total += int'(want.plotted);
        if (want.rdata != 0) nonzero_reads++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= cycle_limit) begin
      $display("Timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin : main
    foreach (frame_model[i]) frame_model[i] = '0;

    // Store starts cleared
    add_cmd(fbld_pkg::FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd0,   1'b0);
    add_cmd(fbld_pkg::FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd863, 1'b0);
    // Full-panel diagonals, both shallow, one rising and one falling
    add_cmd(fbld_pkg::FUNC_DRAW,  8'd0,   8'd0,   8'd95,  8'd67,  1'b1, 10'd0,   1'b0);
    add_cmd(fbld_pkg::FUNC_DRAW,  8'd95,  8'd0,   8'd0,   8'd67,  1'b1, 10'd0,   1'b0);
    // Steep line leaving the panel at the bottom
    add_cmd(fbld_pkg::FUNC_DRAW,  8'd10,  8'd0,   8'd10,  8'd255, 1'b1, 10'd0,   1'b0);
    // Reversed horizontal starting on column 255
    add_cmd(fbld_pkg::FUNC_DRAW,  8'd255, 8'd5,   8'd0,   8'd5,   1'b1, 10'd0,   1'b0);
    // Rows below the panel and a line fully off the panel
    add_cmd(fbld_pkg::FUNC_DRAW,  8'd0,   8'd70,  8'd255, 8'd70,  1'b1, 10'd0,   1'b0);
    add_cmd(fbld_pkg::FUNC_DRAW,  8'd200, 8'd200, 8'd255, 8'd255, 1'b1, 10'd0,   1'b0);
    // Single pixel, on and off the panel
    add_cmd(fbld_pkg::FUNC_DRAW,  8'd7,   8'd7,   8'd7,   8'd7,   1'b1, 10'd0,   1'b0);
    add_cmd(fbld_pkg::FUNC_DRAW,  8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 10'd1023, 1'b0);
    // Full-range diagonal with falling slope
    add_cmd(fbld_pkg::FUNC_DRAW,  8'd0,   8'd255, 8'd255, 8'd0,   1'b1, 10'd0,   1'b0);
    // Line into the bottom page, rows 64..67
    add_cmd(fbld_pkg::FUNC_DRAW,  8'd40,  8'd60,  8'd60,  8'd67,  1'b1, 10'd0,   1'b0);
    add_cmd(fbld_pkg::FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd0,   1'b0);
    add_cmd(fbld_pkg::FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd95,  1'b0);
    add_cmd(fbld_pkg::FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd106, 1'b0);
    add_cmd(fbld_pkg::FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd818, 1'b0);
    // Erase one diagonal, then look again
    add_cmd(fbld_pkg::FUNC_DRAW,  8'd0,   8'd0,   8'd95,  8'd67,  1'b0, 10'd0,   1'b0);
    add_cmd(fbld_pkg::FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd0,   1'b0);
    // Reads past the store
    add_cmd(fbld_pkg::FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd864, 1'b0);
    add_cmd(fbld_pkg::FUNC_READ,  8'hFF,  8'hFF,  8'hFF,  8'hFF,  1'b1, 10'd1023, 1'b0);
    // Unused code with every field bit set
    add_cmd(FUNC_UNUSED,          8'hFF,  8'hFF,  8'hFF,  8'hFF,  1'b1, 10'h3FF, 1'b0);
    // Clear after the pipe drains, then confirm
    add_cmd(fbld_pkg::FUNC_CLEAR, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd0,   1'b1);
    add_cmd(fbld_pkg::FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd818, 1'b0);
    add_cmd(fbld_pkg::FUNC_DRAW,  8'd5,   8'd3,   8'd90,  8'd3,   1'b1, 10'd0,   1'b0);
    add_cmd(fbld_pkg::FUNC_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd50,  1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      add_random_cmd(i == 0 || $urandom_range(0, 199) == 0);
    end
    total_cmds  = cmd_q.size();
    cycle_limit = 4 * (2000 + longint'(total_cmds) * 1400);

    // Reset, released on a falling edge
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cmds < total_cmds) @(negedge clk_i);
    while (expected_q.size() > 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    error_count += expected_q.size();
    $display("Run covered %0d commands: %0d draws writing %0d pixels, %0d clears,",
             accepted_cmds, func_count[fbld_pkg::FUNC_DRAW], pixels_total,
             func_count[fbld_pkg::FUNC_CLEAR]);
    $display("%0d reads (%0d nonzero), %0d unused codes; %0d responses, %0d errors",
             func_count[fbld_pkg::FUNC_READ], nonzero_reads, func_count[FUNC_UNUSED],
             results_seen, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
